>>> design/trsmq_pkg.sv
// Shared types and constants for the TRS matrix-from-quaternion pipeline.
// Standalone package; used by design/trs_matrix_from_quaternion.sv.
package trsmq_pkg;

  localparam int unsigned VAL_W   = 32;  // Q16.16 translation, scale and result
  localparam int unsigned QUAT_W  = 16;  // Q1.14 quaternion component
  localparam int unsigned PROD_W  = 32;  // quaternion product, Q2.28
  localparam int unsigned ROT_W   = 34;  // rotation entry, Q2.28 with headroom
  localparam int unsigned MUL_W   = ROT_W + VAL_W;  // entry times scale
  localparam int unsigned FRAC_SH = 28;  // Q2.28 * Q16.16 -> Q16.16
  localparam int unsigned QUO_W   = MUL_W - FRAC_SH;
  localparam int unsigned N_ENT   = 9;   // 3x3 rotation/scale block
  localparam int unsigned N_PROD  = 9;

  localparam int unsigned IN_TDATA_W  = 6 * VAL_W + 4 * QUAT_W;
  localparam int unsigned OUT_TDATA_W = 12 * VAL_W;

  // product slots
  localparam int unsigned P_XX = 0;
  localparam int unsigned P_YY = 1;
  localparam int unsigned P_ZZ = 2;
  localparam int unsigned P_XY = 3;
  localparam int unsigned P_XZ = 4;
  localparam int unsigned P_YZ = 5;
  localparam int unsigned P_WX = 6;
  localparam int unsigned P_WY = 7;
  localparam int unsigned P_WZ = 8;

  localparam logic signed [ROT_W-1:0] ONE_Q28  = ROT_W'(64'sd1 <<< FRAC_SH);
  localparam logic signed [MUL_W-1:0] HALF_Q28 = MUL_W'(64'sd1 <<< (FRAC_SH - 1));

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef logic signed [VAL_W-1:0]  val_t;
  typedef logic signed [QUAT_W-1:0] quat_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ROT_W-1:0]  rot_t;
  typedef logic signed [MUL_W-1:0]  mul_t;
  typedef logic signed [QUO_W-1:0]  quo_t;

endpackage

>>> design/trs_matrix_from_quaternion.sv
// Top level: builds the top three rows of T*R*S from translation, scale and
// a Q1.14 quaternion. Depends on design/trsmq_pkg.sv.
//
// Usage:
//   Slave stream s_axis_* carries one request per transform: tdata holds
//   tx, ty, tz, sx, sy, sz (Q16.16) and qx, qy, qz, qw (Q1.14); tuser is
//   has_rotation (0 gives the identity rotation).
//   Master stream m_axis_* returns m00..m22 (rotation column times scale,
//   rounded half up and saturated to Q16.16) and m30..m32 (translation).
//   A request passes four registered stages from acceptance to m_axis:
//   quaternion products, rotation entries, entry-by-scale multiply, round
//   and saturate. One request is taken every cycle unless back-pressure on m_axis fills the pipeline.
//   Each stage holds only when it is full and the stage after it cannot
//   take its data, so bubbles close up and the inlet stays open while a
//   result waits at the output register and an earlier stage is empty.
//   Reset clears every stage's valid flag; no request is lost or repeated
//   while m_axis_tready is low.
module trs_matrix_from_quaternion (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tx, ty, tz, sx, sy, sz, qx, qy, qz, qw (lowest bit up)
  input  logic [trsmq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // has_rotation
  input  logic                                 s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22, m30, m31, m32 (lowest bit up)
  output logic [trsmq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  localparam int unsigned VW = trsmq_pkg::VAL_W;
  localparam int unsigned QW = trsmq_pkg::QUAT_W;

  // stage enables, back to front
  logic en1, en2, en3, en4;
  logic v1_q, v2_q, v3_q, v4_q;

  assign en4 = !v4_q || m_axis_tready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign s_axis_tready = en1;
  assign m_axis_tvalid = v4_q;

  // input unpack
  trsmq_pkg::val_t  t_in [3];
  trsmq_pkg::val_t  s_in [3];
  trsmq_pkg::quat_t qx, qy, qz, qw;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t_in[i] = s_axis_tdata[i*VW +: VW];
      s_in[i] = s_axis_tdata[(3+i)*VW +: VW];
    end
    qx = s_axis_tdata[6*VW +: QW];
    qy = s_axis_tdata[6*VW + QW +: QW];
    qz = s_axis_tdata[6*VW + 2*QW +: QW];
    qw = s_axis_tdata[6*VW + 3*QW +: QW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // ---------------- stage 1: quaternion products ----------------
  trsmq_pkg::prod_t p1_d [trsmq_pkg::N_PROD];
  trsmq_pkg::prod_t p1_q [trsmq_pkg::N_PROD];
  trsmq_pkg::val_t  t1_q [3];
  trsmq_pkg::val_t  s1_q [3];
  logic             rot1_q;

  always_comb begin
    p1_d[trsmq_pkg::P_XX] = trsmq_pkg::PROD_W'(qx) * trsmq_pkg::PROD_W'(qx);
    p1_d[trsmq_pkg::P_YY] = trsmq_pkg::PROD_W'(qy) * trsmq_pkg::PROD_W'(qy);
    p1_d[trsmq_pkg::P_ZZ] = trsmq_pkg::PROD_W'(qz) * trsmq_pkg::PROD_W'(qz);
    p1_d[trsmq_pkg::P_XY] = trsmq_pkg::PROD_W'(qx) * trsmq_pkg::PROD_W'(qy);
    p1_d[trsmq_pkg::P_XZ] = trsmq_pkg::PROD_W'(qx) * trsmq_pkg::PROD_W'(qz);
    p1_d[trsmq_pkg::P_YZ] = trsmq_pkg::PROD_W'(qy) * trsmq_pkg::PROD_W'(qz);
    p1_d[trsmq_pkg::P_WX] = trsmq_pkg::PROD_W'(qw) * trsmq_pkg::PROD_W'(qx);
    p1_d[trsmq_pkg::P_WY] = trsmq_pkg::PROD_W'(qw) * trsmq_pkg::PROD_W'(qy);
    p1_d[trsmq_pkg::P_WZ] = trsmq_pkg::PROD_W'(qw) * trsmq_pkg::PROD_W'(qz);
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      p1_q   <= p1_d;
      t1_q   <= t_in;
      s1_q   <= s_in;
      rot1_q <= s_axis_tuser;
    end
  end

  // ---------------- stage 2: rotation entries, index col*3+row ----------------
  trsmq_pkg::rot_t e [trsmq_pkg::N_PROD];
  trsmq_pkg::rot_t r2_d [trsmq_pkg::N_ENT];
  trsmq_pkg::rot_t r2_q [trsmq_pkg::N_ENT];
  trsmq_pkg::val_t t2_q [3];
  trsmq_pkg::val_t s2_q [3];

  always_comb begin
    for (int i = 0; i < trsmq_pkg::N_PROD; i++) begin
      e[i] = trsmq_pkg::ROT_W'(p1_q[i]);
    end
    if (rot1_q) begin
      r2_d[0] = trsmq_pkg::ONE_Q28 -
                ((e[trsmq_pkg::P_YY] + e[trsmq_pkg::P_ZZ]) <<< 1);
      r2_d[1] = (e[trsmq_pkg::P_XY] + e[trsmq_pkg::P_WZ]) <<< 1;
      r2_d[2] = (e[trsmq_pkg::P_XZ] - e[trsmq_pkg::P_WY]) <<< 1;
      r2_d[3] = (e[trsmq_pkg::P_XY] - e[trsmq_pkg::P_WZ]) <<< 1;
      r2_d[4] = trsmq_pkg::ONE_Q28 -
                ((e[trsmq_pkg::P_XX] + e[trsmq_pkg::P_ZZ]) <<< 1);
      r2_d[5] = (e[trsmq_pkg::P_YZ] + e[trsmq_pkg::P_WX]) <<< 1;
      r2_d[6] = (e[trsmq_pkg::P_XZ] + e[trsmq_pkg::P_WY]) <<< 1;
      r2_d[7] = (e[trsmq_pkg::P_YZ] - e[trsmq_pkg::P_WX]) <<< 1;
      r2_d[8] = trsmq_pkg::ONE_Q28 -
                ((e[trsmq_pkg::P_XX] + e[trsmq_pkg::P_YY]) <<< 1);
    end else begin
      for (int i = 0; i < trsmq_pkg::N_ENT; i++) begin
        r2_d[i] = (i % 4 == 0) ? trsmq_pkg::ONE_Q28 : '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      r2_q <= r2_d;
      t2_q <= t1_q;
      s2_q <= s1_q;
    end
  end

  // ---------------- stage 3: entry times column scale ----------------
  trsmq_pkg::mul_t m3_d [trsmq_pkg::N_ENT];
  trsmq_pkg::mul_t m3_q [trsmq_pkg::N_ENT];
  trsmq_pkg::val_t t3_q [3];

  always_comb begin
    for (int i = 0; i < trsmq_pkg::N_ENT; i++) begin
      m3_d[i] = trsmq_pkg::MUL_W'(r2_q[i]) * trsmq_pkg::MUL_W'(s2_q[i/3]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      m3_q <= m3_d;
      t3_q <= t2_q;
    end
  end

  // ---------------- stage 4: round half up, saturate ----------------
  trsmq_pkg::mul_t rnd [trsmq_pkg::N_ENT];
  trsmq_pkg::quo_t quo [trsmq_pkg::N_ENT];
  trsmq_pkg::val_t o4_d [trsmq_pkg::N_ENT];
  trsmq_pkg::val_t o4_q [trsmq_pkg::N_ENT];
  trsmq_pkg::val_t t4_q [3];

  always_comb begin
    for (int i = 0; i < trsmq_pkg::N_ENT; i++) begin
      rnd[i] = m3_q[i] + trsmq_pkg::HALF_Q28;
      // floor division by 2^28
      quo[i] = rnd[i][trsmq_pkg::MUL_W-1:trsmq_pkg::FRAC_SH];
      if (quo[i] > trsmq_pkg::QUO_W'(trsmq_pkg::VAL_MAX)) begin
        o4_d[i] = trsmq_pkg::VAL_MAX;
      end else if (quo[i] < trsmq_pkg::QUO_W'(trsmq_pkg::VAL_MIN)) begin
        o4_d[i] = trsmq_pkg::VAL_MIN;
      end else begin
        o4_d[i] = quo[i][VW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      o4_q <= o4_d;
      t4_q <= t3_q;
    end
  end

  always_comb begin
    for (int i = 0; i < trsmq_pkg::N_ENT; i++) begin
      m_axis_tdata[i*VW +: VW] = o4_q[i];
    end
    for (int i = 0; i < 3; i++) begin
      m_axis_tdata[(trsmq_pkg::N_ENT+i)*VW +: VW] = t4_q[i];
    end
  end

endmodule

>>> tb/tb_top.sv
// Self-checking bench for trs_matrix_from_quaternion: directed table then random requests,
// each result checked field by field against its table entry or a local T*R*S predictor.
// Depends on design/trsmq_pkg.sv and design/trs_matrix_from_quaternion.sv.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam trsmq_pkg::val_t  V_ONE = 32'sh0001_0000;
  localparam trsmq_pkg::val_t  V_MAX = 32'sh7FFF_FFFF;
  localparam trsmq_pkg::val_t  V_MIN = 32'sh8000_0000;
  localparam trsmq_pkg::quat_t Q_ONE = 16'sh4000;
  localparam trsmq_pkg::quat_t Q_MAX = 16'sh7FFF;
  localparam trsmq_pkg::quat_t Q_MIN = 16'sh8000;
  localparam logic signed [39:0] ROT_UNIT = 40'sd1 <<< 28;
  localparam int unsigned N_RAND = 1100;

  // packed so that the low 256 bits are tdata as the port expects
  typedef struct packed {
    logic  has_rot;
    trsmq_pkg::quat_t qw, qz, qy, qx;
    trsmq_pkg::val_t  sz, sy, sx, tz, ty, tx;
  } xform_req_t;

  // m00 in the lowest bits, as on m_axis_tdata
  typedef struct packed {
    trsmq_pkg::val_t m32, m31, m30, m22, m21, m20, m12, m11, m10, m02, m01, m00;
  } xform_mat_t;

  typedef struct {
    xform_req_t req;
    bit         known;
    xform_mat_t want;
  } stim_row_t;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                s_axis_tvalid;
  logic                                s_axis_tready;
  logic [trsmq_pkg::IN_TDATA_W-1:0]    s_axis_tdata;
  logic                                s_axis_tuser;
  logic                                m_axis_tvalid;
  logic                                m_axis_tready;
  logic [trsmq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata;

  xform_mat_t  mat_due [$];
  xform_mat_t  mat_head;
  stim_row_t   dir_tab [$];
  int unsigned bad_cnt = 0;
  bit          calm;
  bit          choke_go;
  bit          choke_done = 1'b0;

  trs_matrix_from_quaternion dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Q2.28 entry times Q16.16 scale, round half up, saturate
  function automatic trsmq_pkg::val_t scale_round(input logic signed [39:0] rot,
                                                  input trsmq_pkg::val_t scl);
    logic signed [79:0] prod;
    logic signed [79:0] quo;
    prod = rot * scl;
    quo  = (prod + (80'sd1 <<< 27)) >>> 28;
    if (quo > 80'sd2147483647) return V_MAX;
    if (quo < -80'sd2147483648) return V_MIN;
    return trsmq_pkg::val_t'(quo[31:0]);
  endfunction

  function automatic xform_mat_t trs_compose(input xform_req_t r);
    trsmq_pkg::quat_t   x, y, z, w;
    logic signed [39:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
    logic signed [39:0] rot [9];
    trsmq_pkg::val_t    scl [3];
    xform_mat_t         m;
    x = r.qx;
    y = r.qy;
    z = r.qz;
    w = r.qw;
    scl[0] = r.sx;
    scl[1] = r.sy;
    scl[2] = r.sz;
    if (r.has_rot) begin
      xx = x * x;  yy = y * y;  zz = z * z;
      xy = x * y;  xz = x * z;  yz = y * z;
      wx = w * x;  wy = w * y;  wz = w * z;
      // column-major: rot[col*3 + row]
      rot[0] = ROT_UNIT - 40'sd2 * (yy + zz);
      rot[1] = 40'sd2 * (xy + wz);
      rot[2] = 40'sd2 * (xz - wy);
      rot[3] = 40'sd2 * (xy - wz);
      rot[4] = ROT_UNIT - 40'sd2 * (xx + zz);
      rot[5] = 40'sd2 * (yz + wx);
      rot[6] = 40'sd2 * (xz + wy);
      rot[7] = 40'sd2 * (yz - wx);
      rot[8] = ROT_UNIT - 40'sd2 * (xx + yy);
    end else begin
      for (int i = 0; i < 9; i++) rot[i] = (i % 4 == 0) ? ROT_UNIT : 40'sd0;
    end
    m = '0;
    for (int i = 0; i < 9; i++) m[i*32 +: 32] = scale_round(rot[i], scl[i / 3]);
    m.m30 = r.tx;
    m.m31 = r.ty;
    m.m32 = r.tz;
    return m;
  endfunction

  function automatic xform_req_t mk_req(input logic hr,
                                        input trsmq_pkg::quat_t qx, qy, qz, qw,
                                        input trsmq_pkg::val_t tx, ty, tz, sx, sy, sz);
    xform_req_t r;
    r.has_rot = hr;
    r.qx = qx;  r.qy = qy;  r.qz = qz;  r.qw = qw;
    r.tx = tx;  r.ty = ty;  r.tz = tz;
    r.sx = sx;  r.sy = sy;  r.sz = sz;
    return r;
  endfunction

  // scaled pure-sign rotation: off-diagonal terms all zero
  function automatic xform_mat_t diag_mat(input trsmq_pkg::val_t d0, d1, d2, t0, t1, t2);
    xform_mat_t m;
    m = '0;
    m.m00 = d0;
    m.m11 = d1;
    m.m22 = d2;
    m.m30 = t0;
    m.m31 = t1;
    m.m32 = t2;
    return m;
  endfunction

  function automatic trsmq_pkg::val_t rand_val();
    case ($urandom_range(0, 7))
      0:       return V_MIN;
      1:       return V_MAX;
      2:       return '0;
      3, 4, 5: return trsmq_pkg::val_t'($urandom);
      default: return trsmq_pkg::val_t'(int'($urandom_range(0, 1048576)) - 524288);
    endcase
  endfunction

  function automatic trsmq_pkg::quat_t rand_quat();
    case ($urandom_range(0, 7))
      0:       return Q_MIN;
      1:       return Q_MAX;
      2, 3, 4: return trsmq_pkg::quat_t'($urandom);
      default: return trsmq_pkg::quat_t'(int'($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  task automatic add_row(input xform_req_t req, input bit known, input xform_mat_t want);
    stim_row_t row;
    row.req   = req;
    row.known = known;
    row.want  = want;
    dir_tab.insert(dir_tab.size(), row);
  endtask

  task automatic offer(input xform_req_t r, input xform_mat_t want);
    while (!calm && $urandom_range(0, 99) < 17) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= r[trsmq_pkg::IN_TDATA_W-1:0];
    s_axis_tuser  <= r.has_rot;
    do @(posedge clk_i); while (!s_axis_tready);
    mat_due.insert(mat_due.size(), want);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (mat_due.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400us;
    $display("tb_top: done, errors");
    $finish;
  end

  // sender
  initial begin
    xform_req_t r;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    calm          = 1'b0;
    choke_go      = 1'b0;

    // identity rotation rows, then half turns and the zero quaternion
    add_row(mk_req(0, 0, 0, 0, 0, 0, 0, 0, V_ONE, V_ONE, V_ONE), 1'b1,
            diag_mat(V_ONE, V_ONE, V_ONE, 0, 0, 0));
    add_row(mk_req(0, 0, 0, 0, 0, 32'sh0002_8000, -32'sh0003_0000, 0,
                   32'sh0002_0000, V_ONE, 32'sh0000_8000), 1'b1,
            diag_mat(32'sh0002_0000, V_ONE, 32'sh0000_8000,
                     32'sh0002_8000, -32'sh0003_0000, 0));
    add_row(mk_req(0, 0, 0, 0, 0, V_MAX, V_MIN, -1, V_MIN, V_MAX, 0), 1'b1,
            diag_mat(V_MIN, V_MAX, 0, V_MAX, V_MIN, -1));
    // quaternion ignored without the rotation flag
    add_row(mk_req(0, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 5, -5, 0, -1, 1, 32'sh8000),
            1'b1, diag_mat(-1, 1, 32'sh8000, 5, -5, 0));
    add_row(mk_req(1, 0, 0, 0, Q_ONE, 1, 2, 3, 32'sh0003_0000, -V_ONE, V_MAX),
            1'b1, diag_mat(32'sh0003_0000, -V_ONE, V_MAX, 1, 2, 3));
    // half turn about z; negating the most negative scale saturates
    add_row(mk_req(1, 0, 0, Q_ONE, 0, 0, 0, 0, V_MIN, V_MAX, V_ONE), 1'b1,
            diag_mat(V_MAX, 32'sh8000_0001, V_ONE, 0, 0, 0));
    add_row(mk_req(1, Q_ONE, 0, 0, 0, V_MIN, 0, V_MAX, V_ONE, V_ONE, V_ONE),
            1'b1, diag_mat(V_ONE, -V_ONE, -V_ONE, V_MIN, 0, V_MAX));
    // half turn about y; -1 lsb rounds to -1 (half up, floor)
    add_row(mk_req(1, 0, Q_ONE, 0, 0, -7, 7, 0, 32'sh0003_0000, -1, 1), 1'b1,
            diag_mat(-32'sh0003_0000, -1, -1, -7, 7, 0));
    add_row(mk_req(1, 0, 0, 0, -Q_ONE, 0, 0, 0, -V_ONE, 1, V_MIN), 1'b1,
            diag_mat(-V_ONE, 1, V_MIN, 0, 0, 0));
    add_row(mk_req(1, 0, 0, 0, 0, 9, 8, 7, V_MAX, V_MIN, -V_ONE), 1'b1,
            diag_mat(V_MAX, V_MIN, -V_ONE, 9, 8, 7));
    // unnormalised: x = -2.0 gives diagonal 1, -7, -7
    add_row(mk_req(1, Q_MIN, 0, 0, 0, 0, 0, 0, V_ONE, V_ONE, -V_ONE), 1'b1,
            diag_mat(V_ONE, 32'shFFF9_0000, 32'sh0007_0000, 0, 0, 0));
    add_row(mk_req(1, 0, 0, 16'sd11585, 16'sd11585, V_ONE, 0, -32'sh4000,
                   V_ONE, V_ONE, V_ONE), 1'b0, '0);
    add_row(mk_req(1, Q_MIN, Q_MIN, Q_MIN, Q_MIN, V_MAX, V_MAX, V_MAX,
                   V_MAX, V_MIN, V_ONE), 1'b0, '0);
    add_row(mk_req(1, Q_MAX, Q_MAX, Q_MAX, Q_MAX, V_MIN, V_MIN, V_MIN,
                   V_MIN, V_MIN, V_MIN), 1'b0, '0);
    add_row(mk_req(1, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 1, -1, 1,
                   V_MAX, V_MAX, V_MAX), 1'b0, '0);
    add_row(mk_req(1, 16'sd6270, 0, 0, 16'sd15137, 0, 0, 0,
                   32'sh0002_0000, 32'sh0000_8000, 3), 1'b0, '0);
    add_row(mk_req(1, 16'sd100, -16'sd200, 16'sd300, 16'sd16000, 0, 0, 0,
                   1, -1, 1), 1'b0, '0);
    add_row(mk_req(1, 1, 1, 1, 1, -1, -1, -1, V_MIN, V_MAX, -V_ONE), 1'b0, '0);
    add_row(mk_req(1, -16'sd9000, 16'sd4000, -16'sd12000, 16'sd7000,
                   32'sh1234_5678, 32'shEDCB_A987, 32'sh0F0F_0F0F,
                   32'sh0005_5555, -32'sh0002_AAAA, 32'sh7654_3210), 1'b0, '0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i])
      offer(dir_tab[i].req, dir_tab[i].known ? dir_tab[i].want : trs_compose(dir_tab[i].req));
    drain();

    for (int n = 0; n < N_RAND; n++) begin
      if (n == 300) choke_go = 1'b1;
      if (n == 550) drain();
      calm = (n >= 700 && n < 900);
      r = mk_req($urandom_range(0, 3) != 0, rand_quat(), rand_quat(), rand_quat(),
                 rand_quat(), rand_val(), rand_val(), rand_val(),
                 rand_val(), rand_val(), rand_val());
      offer(r, trs_compose(r));
    end
    calm = 1'b0;
    drain();
    repeat (8) @(posedge clk_i);
    if (bad_cnt == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

  // receiver: random back-pressure, one long hold-off while requests keep coming
  initial begin
    m_axis_tready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (choke_go && !choke_done) begin
        choke_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end else begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 17);
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (mat_due.size() == 0) begin
        bad_cnt++;
        if (bad_cnt <= 10) $display("unexpected result %h", m_axis_tdata);
      end else begin
        mat_head = mat_due.pop_front();
        for (int i = 0; i < 12; i++) begin
          if (m_axis_tdata[i*32 +: 32] !== mat_head[i*32 +: 32]) begin
            bad_cnt++;
            if (bad_cnt <= 10)
              $display("mismatch m%0d%0d: expected %h, got %h", i / 3, i % 3,
                       mat_head[i*32 +: 32], m_axis_tdata[i*32 +: 32]);
          end
        end
      end
    end
  end

endmodule
